// File: sv/mds_pkg.sv
// Shared constants and codes for the 2x2 mipmap downsampler.
package mds_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 4096;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned SUM_W     = SAMPLE_W + 1;
    localparam int unsigned CFG_W     = 13;
    localparam int unsigned CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 8'd0,
        REG_SRC_HEIGHT = 8'd1
    } cfg_reg_t;

endpackage

// File: sv/mds_if.sv
// Handshake channels for samples, results and configuration writes.
interface mds_sample_if;
    logic                             valid;
    logic                             ready;
    logic [mds_pkg::SAMPLE_W-1:0]     sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mds_result_if;
    logic                             valid;
    logic                             ready;
    logic [mds_pkg::SAMPLE_W-1:0]     avg_elevation;
    logic                             frame_last;

    modport source (output valid, output avg_elevation, output frame_last, input ready);
    modport sink   (input valid, input avg_elevation, input frame_last, output ready);
endinterface

interface mds_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mds_pkg::CFG_IDX_W-1:0]    index;
    logic [mds_pkg::CFG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/mds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mds_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 2048,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mip_downsample_2x2.sv
// Top level of the 2x2 box-filter mipmap downsampler.
//
// Takes one 16-bit sample per clock in raster order, except while the pipeline is full
// and results.ready is low, and emits the truncated mean of each 2x2 block, flagging the
// last result of the frame. A result is registered in s1_reg, alongside the registered
// read of the line store ((MAX_WIDTH+1)/2 words of 17 bits, one write and one read port),
// and then in the result register. Odd widths and heights average the samples that
// exist. Writing src_width or src_height restarts the frame; out-of-range values clamp
// to 1 and to the maximum. No clearing pass after reset.
module mip_downsample_2x2 #(
    parameter int unsigned MAX_WIDTH  = mds_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = mds_pkg::MAX_HEIGHT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mds_cfg_if.sink       cfg,
    mds_sample_if.sink    samples,
    mds_result_if.source  results
);

    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
    localparam int unsigned LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned SW         = mds_pkg::SAMPLE_W;
    localparam int unsigned SUM_W      = mds_pkg::SUM_W;

    typedef struct packed {
        logic [SUM_W-1:0] pair;
        logic             hshift;
        logic             use_line;
        logic             last;
    } stage_t;

    function automatic int unsigned clamp_last(input logic [mds_pkg::CFG_W-1:0] v,
                                               input int unsigned hi);
        int unsigned res;
        if (v == '0)
        begin
            res = 0;
        end
        else if (32'(v) > hi)
        begin
            res = hi - 1;
        end
        else
        begin
            res = 32'(v) - 1;
        end
        return res;
    endfunction

    logic [COL_W-1:0]  w_last_reg;
    logic [ROW_W-1:0]  h_last_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SW-1:0]     left_reg;
    logic              s1_valid_reg;
    stage_t            s1_reg;
    stage_t            s1_next;
    logic              out_valid_reg;
    logic [SW-1:0]     avg_reg;
    logic [SW-1:0]     avg_next;
    logic              last_reg;

    logic              cfg_fire;
    logic              cfg_width_hit;
    logic              cfg_height_hit;
    logic              in_fire;
    logic              out_free;
    logic              last_col;
    logic              last_row;
    logic              odd_col;
    logic              odd_row;
    logic              have_pair;
    logic              emit;
    logic              line_we;
    logic [ADDR_W-1:0] line_addr;
    logic [SUM_W-1:0]  line_rdata;
    logic [SUM_W:0]    total;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_comb
    begin
        cfg_width_hit  = 1'b0;
        cfg_height_hit = 1'b0;
        unique case (mds_pkg::cfg_reg_t'(cfg.index))
            mds_pkg::REG_SRC_WIDTH:  cfg_width_hit  = cfg_fire;
            mds_pkg::REG_SRC_HEIGHT: cfg_height_hit = cfg_fire;
            default:                 ;
        endcase
    end

    assign out_free      = !out_valid_reg || results.ready;
    assign samples.ready = !s1_valid_reg || out_free;
    assign in_fire       = samples.valid && samples.ready;

    assign last_col  = (col_reg == w_last_reg);
    assign last_row  = (row_reg == h_last_reg);
    assign odd_col   = col_reg[0];
    assign odd_row   = row_reg[0];
    assign have_pair = odd_col || last_col;
    assign emit      = have_pair && (odd_row || last_row);
    assign line_we   = in_fire && have_pair && !odd_row && !last_row;
    assign line_addr = ADDR_W'(col_reg >> 1);

    always_comb
    begin
        s1_next.pair     = odd_col ? ({1'b0, left_reg} + {1'b0, samples.sample})
                                   : {1'b0, samples.sample};
        s1_next.hshift   = odd_col;
        s1_next.use_line = odd_row;
        s1_next.last     = odd_row ? (last_row && last_col) : last_col;
    end

    mds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_addr),
        .wdata (s1_next.pair),
        .re    (in_fire),
        .raddr (line_addr),
        .rdata (line_rdata)
    );

    // config and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= COL_W'(MAX_WIDTH - 1);
            h_last_reg <= ROW_W'(MAX_HEIGHT - 1);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_width_hit || cfg_height_hit)
        begin
            if (cfg_width_hit)
            begin
                w_last_reg <= COL_W'(clamp_last(cfg.data, MAX_WIDTH));
            end
            if (cfg_height_hit)
            begin
                h_last_reg <= ROW_W'(clamp_last(cfg.data, MAX_HEIGHT));
            end
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // hold the even-column sample
    always_ff @(posedge clk)
    begin
        if (in_fire && !odd_col && !last_col)
        begin
            left_reg <= samples.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= emit;
        end
        else if (out_free)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= s1_next;
        end
    end

    assign total = {1'b0, line_rdata} + {1'b0, s1_reg.pair};

    always_comb
    begin
        if (s1_reg.use_line)
        begin
            avg_next = s1_reg.hshift ? total[SUM_W:2] : total[SUM_W-1:1];
        end
        else
        begin
            avg_next = s1_reg.hshift ? s1_reg.pair[SUM_W-1:1] : s1_reg.pair[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            avg_reg  <= avg_next;
            last_reg <= s1_reg.last;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.avg_elevation = avg_reg;
    assign results.frame_last    = last_reg;

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_last_reg)
        else $error("column counter beyond row width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_last_reg)
        else $error("row counter beyond frame height");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (s1_valid_reg && out_valid_reg && !results.ready))
        else $error("input stalled without a full pipeline");

endmodule
